// ===== src/frpa_pkg.sv =====
// ----------------------------------------------------------------------------
// frpa_pkg
// Shared types and constants of the frame ring page allocator.
// ----------------------------------------------------------------------------
`default_nettype none
package frpa_pkg;

  localparam int MAX_PAGES_DEF  = 64;
  localparam int MAX_FRAMES_DEF = 8;

  localparam int SIZE_W   = 21;
  localparam int SHIFT_W  = 5;
  localparam int PAGE_W   = 6;
  localparam int OFF_W    = 20;
  localparam int STAT_W   = 2;
  localparam int FCYC_W   = 4;
  localparam int CFG_IDX_W = 1;

  localparam logic [SIZE_W-1:0] PAGE_LIMIT = 21'd1048576;
  localparam logic [SHIFT_W-1:0] MAX_SHIFT = 5'd20;

  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_BIG  = 2'd1;
  localparam logic [STAT_W-1:0] ST_POOL = 2'd2;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_CYCLE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_PAGE_SIZE    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_CYCLES = 1'd1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_AL_CHK,
    S_AL_RDL,
    S_AL_RDF,
    S_AL_CMP,
    S_AL_MISS,
    S_AL_FQ,
    S_CYC_MOD,
    S_CYC_RD,
    S_CYC_WR,
    S_CYC_END,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic scan_start;
    logic rd_list;
    logic rd_fill;
    logic take_fit;
    logic scan_next;
    logic rd_fq;
    logic take_fq;
    logic take_new;
    logic fail_big;
    logic fail_pool;
    logic mod_step;
    logic cl_wr;
    logic cl_done;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic mode_cycle;
    logic oversize;
    logic fits;
    logic i_last;
    logic n_zero;
    logic list_full;
    logic fq_empty;
    logic pool_full;
    logic mod_ge;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

// ===== src/frpa_ctrl.sv =====
// ----------------------------------------------------------------------------
// frpa_ctrl
// Sequencer that steps the datapath through allocation and frame advance.
// ----------------------------------------------------------------------------
`default_nettype none
module frpa_ctrl (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_ready,
  input  frpa_pkg::sts_t     sts,
  output frpa_pkg::cmd_t     cmd
);
  import frpa_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_AL_CHK;
        end
      end
      S_AL_CHK: begin
        if (sts.mode_cycle) begin
          state_nxt = S_CYC_MOD;
        end else if (sts.oversize) begin
          cmd.fail_big = 1'b1;
          state_nxt    = S_EMIT;
        end else begin
          cmd.scan_start = 1'b1;
          state_nxt      = sts.n_zero ? S_AL_MISS : S_AL_RDL;
        end
      end
      S_AL_RDL: begin
        cmd.rd_list = 1'b1;
        state_nxt   = S_AL_RDF;
      end
      S_AL_RDF: begin
        cmd.rd_fill = 1'b1;
        state_nxt   = S_AL_CMP;
      end
      S_AL_CMP: begin
        if (sts.fits) begin
          cmd.take_fit = 1'b1;
          state_nxt    = S_EMIT;
        end else if (sts.i_last) begin
          state_nxt = S_AL_MISS;
        end else begin
          cmd.scan_next = 1'b1;
          state_nxt     = S_AL_RDL;
        end
      end
      S_AL_MISS: begin
        priority if (sts.list_full) begin
          cmd.fail_pool = 1'b1;
          state_nxt     = S_EMIT;
        end else if (!sts.fq_empty) begin
          cmd.rd_fq = 1'b1;
          state_nxt = S_AL_FQ;
        end else if (!sts.pool_full) begin
          cmd.take_new = 1'b1;
          state_nxt    = S_EMIT;
        end else begin
          cmd.fail_pool = 1'b1;
          state_nxt     = S_EMIT;
        end
      end
      S_AL_FQ: begin
        cmd.take_fq = 1'b1;
        state_nxt   = S_EMIT;
      end
      S_CYC_MOD: begin
        if (sts.mod_ge) begin
          cmd.mod_step = 1'b1;
        end else begin
          cmd.scan_start = 1'b1;
          state_nxt      = sts.n_zero ? S_CYC_END : S_CYC_RD;
        end
      end
      S_CYC_RD: begin
        cmd.rd_list = 1'b1;
        state_nxt   = S_CYC_WR;
      end
      S_CYC_WR: begin
        cmd.cl_wr = 1'b1;
        if (sts.i_last) begin
          state_nxt = S_CYC_END;
        end else begin
          cmd.scan_next = 1'b1;
          state_nxt     = S_CYC_RD;
        end
      end
      S_CYC_END: begin
        cmd.cl_done = 1'b1;
        state_nxt   = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== src/frpa_dp.sv =====
// ----------------------------------------------------------------------------
// frpa_dp
// Page fill, frame list and free queue storage with the scan datapath.
// ----------------------------------------------------------------------------
`default_nettype none
module frpa_dp #(
  parameter int MAX_PAGES  = frpa_pkg::MAX_PAGES_DEF,
  parameter int MAX_FRAMES = frpa_pkg::MAX_FRAMES_DEF
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                cfg_we,
  input  wire  [frpa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [frpa_pkg::SIZE_W-1:0]        cfg_wdata,
  input  wire                                in_mode,
  input  wire  [frpa_pkg::SIZE_W-1:0]        in_size,
  input  wire  [frpa_pkg::SHIFT_W-1:0]       in_shift,
  input  frpa_pkg::cmd_t                     cmd,
  output frpa_pkg::sts_t                     sts,
  input  wire                                out_ready,
  output logic                               out_valid,
  output logic [frpa_pkg::PAGE_W-1:0]        out_page,
  output logic [frpa_pkg::OFF_W-1:0]         out_off,
  output logic [frpa_pkg::STAT_W-1:0]        out_stat
);
  import frpa_pkg::*;

  localparam int PW  = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int CW  = $clog2(MAX_PAGES + 1);
  localparam int FW  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int EW  = $clog2(MAX_FRAMES + 16);
  localparam int LD  = MAX_FRAMES * MAX_PAGES;
  localparam int LAW = (LD > 1) ? $clog2(LD) : 1;
  localparam int NW  = SIZE_W + 1;

  logic [SIZE_W-1:0]  page_size_r;
  logic [FCYC_W-1:0]  frame_cycles_r;

  logic               mode_r;
  logic               big_r;
  logic [NW-1:0]      need_r;
  logic [EW-1:0]      nf_r;
  logic [FW-1:0]      cur_r;
  logic [CW-1:0]      idx_r;
  logic [CW-1:0]      len_r [MAX_FRAMES];
  logic [CW-1:0]      fq_cnt_r;
  logic [PW-1:0]      fq_head_r;
  logic [CW-1:0]      created_r;
  logic [PW-1:0]      pg_r;

  logic [SIZE_W-1:0]  fill_mem [MAX_PAGES];
  logic [PW-1:0]      list_mem [LD];
  logic [PW-1:0]      fq_mem   [MAX_PAGES];
  logic [PW-1:0]      list_q;
  logic [SIZE_W-1:0]  fill_q;
  logic [PW-1:0]      fq_q;

  logic [PAGE_W-1:0]  res_page_r;
  logic [OFF_W-1:0]   res_off_r;
  logic [STAT_W-1:0]  res_stat_r;
  logic               out_valid_r;
  logic [PAGE_W-1:0]  out_page_r;
  logic [OFF_W-1:0]   out_off_r;
  logic [STAT_W-1:0]  out_stat_r;

  logic [SIZE_W-1:0]  cap;
  logic [EW-1:0]      eff;
  logic [FW-1:0]      fsel;
  logic [CW-1:0]      n_cur;
  logic [LAW-1:0]     rd_addr;
  logic [LAW-1:0]     app_addr;
  logic [SIZE_W-1:0]  mask;
  logic [NW-1:0]      need_calc;
  logic [NW:0]        fit_sum;
  logic [CW:0]        tail_sum;
  logic [PW-1:0]      tail;
  logic               fill_we;
  logic [PW-1:0]      fill_wa;
  logic [SIZE_W-1:0]  fill_wd;

  always_comb begin
    cap = (page_size_r > PAGE_LIMIT) ? PAGE_LIMIT : page_size_r;
    if (frame_cycles_r == '0) begin
      eff = EW'(1);
    end else if (EW'(frame_cycles_r) > EW'(MAX_FRAMES)) begin
      eff = EW'(MAX_FRAMES);
    end else begin
      eff = EW'(frame_cycles_r);
    end
    fsel     = mode_r ? FW'(nf_r) : cur_r;
    n_cur    = len_r[fsel];
    rd_addr  = LAW'(int'(fsel) * MAX_PAGES + int'(idx_r));
    app_addr = LAW'(int'(fsel) * MAX_PAGES + int'(n_cur));
    mask      = (SIZE_W'(1) << in_shift) - SIZE_W'(1);
    need_calc = ({1'b0, in_size} + {1'b0, mask}) & ~{1'b0, mask};
    fit_sum   = {2'b0, fill_q} + {1'b0, need_r};
    tail_sum  = (CW+1)'(fq_head_r) + (CW+1)'(fq_cnt_r);
    tail      = (tail_sum >= (CW+1)'(MAX_PAGES)) ? PW'(tail_sum - (CW+1)'(MAX_PAGES))
                                                 : PW'(tail_sum);
  end

  always_comb begin
    sts.mode_cycle = mode_r;
    sts.oversize   = big_r || (need_r > {1'b0, cap});
    sts.fits       = (fit_sum <= {2'b0, cap});
    sts.i_last     = ((CW+1)'(idx_r) + (CW+1)'(1)) >= (CW+1)'(n_cur);
    sts.n_zero     = (n_cur == '0);
    sts.list_full  = (n_cur >= CW'(MAX_PAGES));
    sts.fq_empty   = (fq_cnt_r == '0);
    sts.pool_full  = (created_r >= CW'(MAX_PAGES));
    sts.mod_ge     = (nf_r >= eff);
    sts.out_free   = !out_valid_r || out_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_size_r    <= PAGE_LIMIT >> 4;
      frame_cycles_r <= FCYC_W'(3);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PAGE_SIZE:    page_size_r    <= cfg_wdata;
        REG_FRAME_CYCLES: frame_cycles_r <= cfg_wdata[FCYC_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= in_mode;
      big_r  <= (in_shift > MAX_SHIFT) && (in_size != '0);
      need_r <= need_calc;
      nf_r   <= EW'(cur_r) + EW'(1);
    end
    if (cmd.mod_step) begin
      nf_r <= nf_r - eff;
    end
    if (cmd.scan_start) begin
      idx_r <= '0;
    end else if (cmd.scan_next) begin
      idx_r <= idx_r + CW'(1);
    end
    if (cmd.rd_fill) begin
      pg_r <= list_q;
    end
  end

  always_comb begin
    fill_we = 1'b1;
    fill_wa = list_q;
    fill_wd = '0;
    priority case (1'b1)
      cmd.take_fit: begin
        fill_wa = pg_r;
        fill_wd = fit_sum[SIZE_W-1:0];
      end
      cmd.take_new: begin
        fill_wa = PW'(created_r);
        fill_wd = need_r[SIZE_W-1:0];
      end
      cmd.take_fq: begin
        fill_wa = fq_q;
        fill_wd = need_r[SIZE_W-1:0];
      end
      cmd.cl_wr: begin
        fill_wa = list_q;
        fill_wd = '0;
      end
      default: fill_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (fill_we) begin
      fill_mem[fill_wa] <= fill_wd;
    end
    fill_q <= fill_mem[list_q];
  end

  always_ff @(posedge clk) begin
    if (cmd.take_new) begin
      list_mem[app_addr] <= PW'(created_r);
    end else if (cmd.take_fq) begin
      list_mem[app_addr] <= fq_q;
    end
    if (cmd.rd_list) begin
      list_q <= list_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cl_wr && (fq_cnt_r < CW'(MAX_PAGES))) begin
      fq_mem[tail] <= list_q;
    end
    if (cmd.rd_fq) begin
      fq_q <= fq_mem[fq_head_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < MAX_FRAMES; k++) begin
        len_r[k] <= '0;
      end
      fq_cnt_r  <= '0;
      fq_head_r <= '0;
      created_r <= '0;
      cur_r     <= '0;
    end else begin
      if (cmd.take_new || cmd.take_fq) begin
        len_r[fsel] <= n_cur + CW'(1);
      end
      if (cmd.take_new) begin
        created_r <= created_r + CW'(1);
      end
      if (cmd.take_fq) begin
        fq_head_r <= (int'(fq_head_r) == MAX_PAGES - 1) ? '0 : fq_head_r + PW'(1);
        fq_cnt_r  <= fq_cnt_r - CW'(1);
      end else if (cmd.cl_wr && (fq_cnt_r < CW'(MAX_PAGES))) begin
        fq_cnt_r <= fq_cnt_r + CW'(1);
      end
      if (cmd.cl_done) begin
        len_r[fsel] <= '0;
        cur_r       <= fsel;
      end
    end
  end

  always_ff @(posedge clk) begin
    priority case (1'b1)
      cmd.take_fit: begin
        res_page_r <= PAGE_W'(pg_r);
        res_off_r  <= fill_q[OFF_W-1:0];
        res_stat_r <= ST_OK;
      end
      cmd.take_new: begin
        res_page_r <= PAGE_W'(created_r);
        res_off_r  <= '0;
        res_stat_r <= ST_OK;
      end
      cmd.take_fq: begin
        res_page_r <= PAGE_W'(fq_q);
        res_off_r  <= '0;
        res_stat_r <= ST_OK;
      end
      cmd.fail_big: begin
        res_page_r <= '0;
        res_off_r  <= '0;
        res_stat_r <= ST_BIG;
      end
      cmd.fail_pool: begin
        res_page_r <= '0;
        res_off_r  <= '0;
        res_stat_r <= ST_POOL;
      end
      cmd.cl_done: begin
        res_page_r <= '0;
        res_off_r  <= '0;
        res_stat_r <= ST_OK;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.emit) begin
      out_page_r <= res_page_r;
      out_off_r  <= res_off_r;
      out_stat_r <= res_stat_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_page  = out_page_r;
  assign out_off   = out_off_r;
  assign out_stat  = out_stat_r;

  a_fq_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fq_cnt_r <= CW'(MAX_PAGES))
    else $error("Free queue count exceeds the pool.");

  a_created_bound: assert property (@(posedge clk) disable iff (!rst_n)
    created_r <= CW'(MAX_PAGES))
    else $error("Created page count exceeds the pool.");

  a_pool_sum: assert property (@(posedge clk) disable iff (!rst_n)
    fq_cnt_r <= created_r)
    else $error("More free pages than created pages.");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || out_ready))
    else $error("Result overwrote a pending beat.");

endmodule
`default_nettype wire

// ===== src/frame_ring_page_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// frame_ring_page_allocator_unit
// Sequence: an oversized request goes straight to its error result; an
//   allocation scans the pages of the current frame and takes the first that
//   fits, else takes a free page, creates one or reports the pool exhausted;
//   a frame advance subtracts the ring count while the frame index wraps,
//   then frees each page of the new frame onto the free queue.
// Throughput: one beat in flight; the page scan through the list and fill
//   memories sets the rate. A new beat is taken in the cycle after the result
//   registers, even while that result waits.
// Reset: synchronous active-low; counts, lengths and control clear at once.
// ----------------------------------------------------------------------------
`default_nettype none
module frame_ring_page_allocator_unit #(
  parameter int MAX_PAGES  = frpa_pkg::MAX_PAGES_DEF,
  parameter int MAX_FRAMES = frpa_pkg::MAX_FRAMES_DEF
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             cfg_we,
  input  wire  [frpa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire  [frpa_pkg::SIZE_W-1:0]     cfg_wdata,
  input  wire                             in_tvalid,
  output logic                            in_tready,
  // alloc_size [20:0], align_shift [25:21], zero fill above.
  input  wire  [31:0]                     in_tdata,
  // mode [0].
  input  wire                             in_tuser,
  output logic                            out_tvalid,
  input  wire                             out_tready,
  // page_index [5:0], offset [25:6], zero fill above.
  output logic [31:0]                     out_tdata,
  // status [1:0].
  output logic [1:0]                      out_tuser
);
  import frpa_pkg::*;

  cmd_t              cmd;
  sts_t              sts;
  logic [PAGE_W-1:0] page;
  logic [OFF_W-1:0]  off;

  frpa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  frpa_dp #(
    .MAX_PAGES  (MAX_PAGES),
    .MAX_FRAMES (MAX_FRAMES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_mode   (in_tuser),
    .in_size   (in_tdata[20:0]),
    .in_shift  (in_tdata[25:21]),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_page  (page),
    .out_off   (off),
    .out_stat  (out_tuser)
  );

  assign out_tdata = {6'b0, off, page};

endmodule
`default_nettype wire
